>>> hdl/bald_pkg.sv
// Shared types, widths and helpers of the box average line downscaler.
package bald_pkg;

    localparam int unsigned LEN_W      = 13;
    localparam int unsigned SAMPLE_W   = 8;
    localparam int unsigned SUM_W      = LEN_W + SAMPLE_W;
    localparam int unsigned ERR_W      = LEN_W + 2;
    localparam int unsigned AVG_W      = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam int unsigned DEF_MAX_LINE      = 4096;
    localparam int unsigned DEF_FRACTION_BITS = 8;

    localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;
    localparam logic [LEN_W-1:0] LEN_MIN   = 13'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LENGTH = 2'd1;

    // One closed run, handed from the front to the divider.
    typedef struct packed {
        logic             last;
        logic [LEN_W-1:0] count;
        logic [SUM_W-1:0] sum;
    } t_run;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

    // Clamps a programmed length to [2, max_len].
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                   input int unsigned max_len);
        logic [LEN_W-1:0] r;
        r = v;
        if (v < LEN_MIN) begin
            r = LEN_MIN;
        end else if (32'(v) > max_len) begin
            r = LEN_W'(max_len);
        end
        return r;
    endfunction

endpackage

>>> hdl/box_average_line_downscaler.sv
// A sample that closes a run enters the two-entry run queue; the one-bit-per-cycle divider
// loads the run from it, forms the quotient and registers the average in its result register.
// One sample is taken per cycle while the two-entry run queue has room; the divider takes a new
// run from the queue only after it has delivered the average of the last one.
// Reset is synchronous and active low; both lengths return to 4096 and the line restarts.
// Top level of the box average line downscaler.
module box_average_line_downscaler #(
    parameter int unsigned MAX_LINE      = bald_pkg::DEF_MAX_LINE,
    parameter int unsigned FRACTION_BITS = bald_pkg::DEF_FRACTION_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bald_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bald_pkg::LEN_W-1:0]     i_cfg_data,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [bald_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [bald_pkg::AVG_W-1:0]     o_average,
    output logic                           o_line_end
);
    import bald_pkg::*;

    logic accept;
    logic run_push, run_pop, q_full, q_empty;
    t_run run_in, run_out;

    assign o_full = q_full;
    assign accept = i_push && !q_full;

    bald_front #(
        .MAX_LINE(MAX_LINE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_sample   (i_sample),
        .o_run_push (run_push),
        .o_run      (run_in)
    );

    bald_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (run_push),
        .i_data (run_in),
        .i_pop  (run_pop),
        .o_data (run_out),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    bald_divider #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_run_valid(!q_empty),
        .i_run      (run_out),
        .o_run_pop  (run_pop),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_average  (o_average),
        .o_line_end (o_line_end)
    );

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        run_push |-> !q_full)
        else $error("run pushed into a full queue");

    a_run_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        run_push |-> (run_in.count != '0))
        else $error("closed run has zero pixels");

    a_pop_only_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        run_pop |-> !q_empty)
        else $error("divider took a run from an empty queue");
`endif

endmodule

>>> hdl/bald_front.sv
// Front end: configuration, run grouping by error term, run sum and count.
module bald_front #(
    parameter int unsigned MAX_LINE = bald_pkg::DEF_MAX_LINE
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bald_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bald_pkg::LEN_W-1:0]     i_cfg_data,
    input  logic                           i_accept,
    input  logic [bald_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                           o_run_push,
    output bald_pkg::t_run                 o_run
);
    import bald_pkg::*;

    logic [LEN_W-1:0]        r_src_len, r_dst_len;
    logic [LEN_W-1:0]        r_pos, n_pos;
    logic signed [ERR_W-1:0] r_err, n_err;
    logic [SUM_W-1:0]        r_sum, n_sum;
    logic [LEN_W-1:0]        r_cnt, n_cnt;

    logic [LEN_W-1:0]        src_eff, dst_clamp, dst_eff;
    logic [LEN_W-1:0]        new_src, new_dst, new_src_eff;
    logic signed [ERR_W-1:0] err_add, err_start;
    logic [SUM_W-1:0]        sum_add;
    logic [LEN_W-1:0]        cnt_add;
    logic                    close_run, last_pix;

    assign src_eff   = clamp_len(r_src_len, MAX_LINE);
    assign dst_clamp = clamp_len(r_dst_len, MAX_LINE);
    assign dst_eff   = (dst_clamp > src_eff) ? src_eff : dst_clamp;

    assign sum_add  = r_sum + SUM_W'(i_sample);
    assign cnt_add  = r_cnt + LEN_W'(1);
    assign err_add  = r_err + $signed({2'b00, dst_eff});
    // Doubling the term keeps the compare exact for odd source lengths.
    assign close_run = $signed({err_add, 1'b0}) >= $signed({3'b000, src_eff});
    assign last_pix  = ({1'b0, r_pos} + (LEN_W+1)'(1)) >= {1'b0, src_eff};

    // Lengths as they stand after a configuration write, for the restart.
    assign new_src     = (i_cfg_we && i_cfg_index == REG_SOURCE_LENGTH) ? i_cfg_data
                                                                         : r_src_len;
    assign new_dst     = (i_cfg_we && i_cfg_index == REG_TARGET_LENGTH) ? i_cfg_data
                                                                         : r_dst_len;
    assign new_src_eff = clamp_len(new_src, MAX_LINE);
    assign err_start   = -$signed({3'b000, new_src_eff[LEN_W-1:1]});

    assign o_run_push = i_accept && (close_run || last_pix);
    assign o_run.last  = last_pix;
    assign o_run.count = cnt_add;
    assign o_run.sum   = sum_add;

    always_comb begin
        n_pos = r_pos;
        n_err = r_err;
        n_sum = r_sum;
        n_cnt = r_cnt;
        if (i_cfg_we && (i_cfg_index == REG_SOURCE_LENGTH ||
                         i_cfg_index == REG_TARGET_LENGTH)) begin
            n_pos = '0;
            n_err = err_start;
            n_sum = '0;
            n_cnt = '0;
        end else if (i_accept) begin
            if (last_pix) begin
                n_pos = '0;
                n_err = err_start;
                n_sum = '0;
                n_cnt = '0;
            end else begin
                n_pos = r_pos + LEN_W'(1);
                n_err = close_run ? (err_add - $signed({2'b00, src_eff})) : err_add;
                n_sum = close_run ? '0 : sum_add;
                n_cnt = close_run ? '0 : cnt_add;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_len <= LEN_RESET;
            r_dst_len <= LEN_RESET;
            r_pos     <= '0;
            r_err     <= -$signed({2'b00, clamp_len(LEN_RESET, MAX_LINE) >> 1});
            r_sum     <= '0;
            r_cnt     <= '0;
        end else begin
            r_src_len <= new_src;
            r_dst_len <= new_dst;
            r_pos     <= n_pos;
            r_err     <= n_err;
            r_sum     <= n_sum;
            r_cnt     <= n_cnt;
        end
    end

endmodule

>>> hdl/bald_queue.sv
// Two-entry queue of closed runs between the front end and the divider.
module bald_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bald_pkg::t_run i_data,
    input  logic           i_pop,
    output bald_pkg::t_run o_data,
    output logic           o_full,
    output logic           o_empty
);
    import bald_pkg::*;

    t_run       r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_level;

    logic do_push, do_pop;

    assign o_full  = (r_level == 2'd2);
    assign o_empty = (r_level == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_level <= r_level + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

>>> hdl/bald_divider.sv
// Back end: shift-subtract divider forming the scaled run average, plus result register.
module bald_divider #(
    parameter int unsigned FRACTION_BITS = bald_pkg::DEF_FRACTION_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_run_valid,
    input  bald_pkg::t_run             i_run,
    output logic                       o_run_pop,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic [bald_pkg::AVG_W-1:0] o_average,
    output logic                       o_line_end
);
    import bald_pkg::*;

    localparam int unsigned QW     = SUM_W + FRACTION_BITS;
    localparam int unsigned STEP_W = $clog2(QW);

    t_div_state        r_state, n_state;
    logic [QW-1:0]     r_dvd;
    logic [LEN_W-1:0]  r_rem;
    logic [LEN_W-1:0]  r_div;
    logic              r_last;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic [AVG_W-1:0]  r_avg;
    logic              r_line_end;

    logic [LEN_W:0]    rem_sh;
    logic              rem_ge;
    logic [LEN_W:0]    rem_sub;
    logic              load, advance, deliver;
    logic [AVG_W-1:0]  avg_sat;

    assign rem_sh  = {r_rem, r_dvd[QW-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};
    // Quotients that do not fit in the result width saturate.
    assign avg_sat = (r_dvd[QW-1:AVG_W] != '0) ? '1 : r_dvd[AVG_W-1:0];

    always_comb begin
        n_state = r_state;
        load    = 1'b0;
        advance = 1'b0;
        deliver = 1'b0;
        unique case (r_state)
            DIV_IDLE: begin
                if (i_run_valid) begin
                    load    = 1'b1;
                    n_state = DIV_RUN;
                end
            end
            DIV_RUN: begin
                advance = 1'b1;
                if (r_step == STEP_W'(QW - 1)) begin
                    n_state = DIV_DONE;
                end
            end
            DIV_DONE: begin
                if (!r_out_valid || i_pop) begin
                    deliver = 1'b1;
                    n_state = DIV_IDLE;
                end
            end
            default: n_state = DIV_IDLE;
        endcase
    end

    assign o_run_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_dvd  <= {i_run.sum, FRACTION_BITS'(0)};
            r_rem  <= '0;
            r_div  <= i_run.count;
            r_last <= i_run.last;
            r_step <= '0;
        end else if (advance) begin
            // The freed low bit of the dividend collects the quotient.
            r_dvd  <= {r_dvd[QW-2:0], rem_ge};
            r_rem  <= rem_ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (deliver) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (deliver) begin
            r_avg      <= avg_sat;
            r_line_end <= r_last;
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_average  = r_avg;
    assign o_line_end = r_line_end;

endmodule
